// ===== rtl/core/ucb_csr_pkg.sv =====
`default_nettype none
package ucb_csr_pkg;

  localparam int DEVICES        = 5;
  localparam int CHANNELS       = 2;
  localparam int SPREAD_FACTORS = 3;
  localparam int ROUND_BITS     = 16;

  localparam int ARMS    = CHANNELS * SPREAD_FACTORS;
  localparam int ENTRIES = DEVICES * ARMS;

  localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int ARM_W  = (ARMS > 1) ? $clog2(ARMS) : 1;
  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SF_W   = (SPREAD_FACTORS > 1) ? $clog2(SPREAD_FACTORS) : 1;
  localparam int E_W    = $clog2(ROUND_BITS);
  localparam int POS_W  = $clog2(DEVICES * ARMS + 1);

  // fixed field widths
  localparam int COIN_W = 25;
  localparam int MASK_W = 5;
  localparam int SUM_W  = 20;
  localparam int PLAY_W = 16;
  localparam int CNT_W  = 20;
  localparam int LN_W   = 20;
  localparam int FRAC_W = 16;
  localparam int X_W    = 31;
  localparam int DIVD_W = 37;
  localparam int DIVS_W = 20;
  localparam int SQ_W   = 19;
  localparam int IDX_W  = 20;
  localparam int MEAN_W = 40;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [PLAY_W-1:0] PLAY_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic signed [MEAN_W-1:0] IDX_HI = 40'sd524287;
  localparam logic signed [MEAN_W-1:0] IDX_LO = -40'sd524288;
  localparam logic signed [MEAN_W-1:0] MEAN_ONE = 40'sd65536;

  typedef struct packed {
    logic              round_start;
    logic              vdiv_start;
    logic              mdiv_start;
    logic              sqrt_start;
    logic              compare;
    logic              update;
    logic              round_end;
    logic [DEV_W-1:0]  dev;
    logic [ARM_W-1:0]  arm;
    logic [CH_W-1:0]   ch;
    logic [SF_W-1:0]   sf;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic div_done;
    logic sqrt_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ucb_csr_div.sv =====
`default_nettype none
module ucb_csr_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ucb_csr_pkg::DIVD_W-1:0] dividend,
  input  wire logic [ucb_csr_pkg::DIVS_W-1:0] divisor,
  output logic                                done,
  output logic [ucb_csr_pkg::DIVD_W-1:0]      quotient
);
  localparam int CW = $clog2(ucb_csr_pkg::DIVD_W + 1);

  logic [ucb_csr_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [ucb_csr_pkg::DIVS_W-1:0] rem_r, rem_nxt, div_r, div_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt, done_r, done_nxt;
  logic [ucb_csr_pkg::DIVS_W:0]   rem_sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quo_r[ucb_csr_pkg::DIVD_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step: one quotient bit
      if (rem_sh >= {1'b0, div_r}) begin
        rem_nxt = ucb_csr_pkg::DIVS_W'(rem_sh - {1'b0, div_r});
        quo_nxt = {quo_r[ucb_csr_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[ucb_csr_pkg::DIVS_W-1:0];
        quo_nxt = {quo_r[ucb_csr_pkg::DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(ucb_csr_pkg::DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/ucb_csr_ctrl.sv =====
`default_nettype none
module ucb_csr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire ucb_csr_pkg::stat_t  stat,
  output ucb_csr_pkg::cmd_t        cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOG    = 4'd1;
  localparam logic [3:0] S_V_GO   = 4'd2;
  localparam logic [3:0] S_V_WAIT = 4'd3;
  localparam logic [3:0] S_S_GO   = 4'd4;
  localparam logic [3:0] S_S_WAIT = 4'd5;
  localparam logic [3:0] S_M_GO   = 4'd6;
  localparam logic [3:0] S_M_WAIT = 4'd7;
  localparam logic [3:0] S_CMP    = 4'd8;
  localparam logic [3:0] S_UPD    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]                     state_r, state_nxt;
  logic [ucb_csr_pkg::DEV_W-1:0]  dev_r, dev_nxt;
  logic [ucb_csr_pkg::ARM_W-1:0]  arm_r, arm_nxt;
  logic [ucb_csr_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [ucb_csr_pkg::SF_W-1:0]   sf_r, sf_nxt;
  logic [ucb_csr_pkg::ADDR_W-1:0] addr_r, addr_nxt;

  always_comb begin
    state_nxt = state_r;
    dev_nxt   = dev_r;
    arm_nxt   = arm_r;
    ch_nxt    = ch_r;
    sf_nxt    = sf_r;
    addr_nxt  = addr_r;
    cmd       = '0;
    cmd.dev   = dev_r;
    cmd.arm   = arm_r;
    cmd.ch    = ch_r;
    cmd.sf    = sf_r;
    cmd.addr  = addr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.round_start = 1'b1;
          dev_nxt   = '0;
          arm_nxt   = '0;
          ch_nxt    = '0;
          sf_nxt    = '0;
          addr_nxt  = '0;
          state_nxt = S_LOG;
        end
      end
      S_LOG:    if (stat.log_done) state_nxt = S_V_GO;
      S_V_GO: begin
        cmd.vdiv_start = 1'b1;
        state_nxt = S_V_WAIT;
      end
      S_V_WAIT: if (stat.div_done) state_nxt = S_S_GO;
      S_S_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_S_WAIT;
      end
      S_S_WAIT: if (stat.sqrt_done) state_nxt = S_M_GO;
      S_M_GO: begin
        cmd.mdiv_start = 1'b1;
        state_nxt = S_M_WAIT;
      end
      S_M_WAIT: if (stat.div_done) state_nxt = S_CMP;
      S_CMP: begin
        cmd.compare = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (arm_r == ucb_csr_pkg::ARM_W'(ucb_csr_pkg::ARMS - 1)) begin
          state_nxt = S_UPD;
        end else begin
          arm_nxt = arm_r + 1'b1;
          if (sf_r == ucb_csr_pkg::SF_W'(ucb_csr_pkg::SPREAD_FACTORS - 1)) begin
            sf_nxt = '0;
            ch_nxt = ch_r + 1'b1;
          end else begin
            sf_nxt = sf_r + 1'b1;
          end
          state_nxt = S_V_GO;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          arm_nxt = '0;
          ch_nxt  = '0;
          sf_nxt  = '0;
          if (dev_r == ucb_csr_pkg::DEV_W'(ucb_csr_pkg::DEVICES - 1)) begin
            cmd.round_end = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            dev_nxt   = dev_r + 1'b1;
            state_nxt = S_V_GO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    dev_r  <= dev_nxt;
    arm_r  <= arm_nxt;
    ch_r   <= ch_nxt;
    sf_r   <= sf_nxt;
    addr_r <= addr_nxt;
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
endmodule
`default_nettype wire

// ===== rtl/core/ucb_csr_dp.sv =====
`default_nettype none
module ucb_csr_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ucb_csr_pkg::cmd_t              cmd,
  output ucb_csr_pkg::stat_t                  stat,
  input  wire logic [ucb_csr_pkg::COIN_W-1:0] tie_coins,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ucb_csr_pkg::MASK_W-1:0] cfg_wr_data,
  output logic [2:0]                          device_index,
  output logic                                chosen_channel,
  output logic [1:0]                          chosen_spreading,
  output logic                                delivered,
  output logic [ucb_csr_pkg::CNT_W-1:0]       delivered_total,
  output logic                                last_of_round
);
  localparam int RB = ucb_csr_pkg::ROUND_BITS;
  localparam int DD = ucb_csr_pkg::DIVD_W;
  localparam int SW = ucb_csr_pkg::SUM_W;
  localparam int PW = ucb_csr_pkg::PLAY_W;
  localparam int QW = ucb_csr_pkg::SQ_W;
  localparam int LCW = $clog2(ucb_csr_pkg::FRAC_W + 2);
  localparam int SCW = $clog2(ucb_csr_pkg::SQ_W + 1);

  // state and configuration
  logic [RB-1:0]                       round_r;
  logic [ucb_csr_pkg::MASK_W-1:0]      mask_r;
  logic [ucb_csr_pkg::COIN_W-1:0]      coins_r;
  logic [ucb_csr_pkg::ARMS-1:0]        taken_r;
  logic [ucb_csr_pkg::CNT_W-1:0]       dcnt_r;
  logic [SW-1:0]                       sum_mem [ucb_csr_pkg::ENTRIES];
  logic [PW-1:0]                       play_mem [ucb_csr_pkg::ENTRIES];

  // log engine
  logic [ucb_csr_pkg::E_W-1:0]    e_r;
  logic [ucb_csr_pkg::X_W-1:0]    x_r;
  logic [ucb_csr_pkg::FRAC_W-1:0] frac_r;
  logic [LCW-1:0]                 lcnt_r;
  logic                           lbusy_r, ldone_r;
  logic [ucb_csr_pkg::LN_W-1:0]   ln_r;
  logic [ucb_csr_pkg::E_W-1:0]    e_top;
  logic [2*ucb_csr_pkg::X_W-1:0]  xsq;
  logic [31:0]                    xsh;
  logic [51:0]                    ln_prod;

  // sqrt engine
  logic [DD-1:0]   v_r;
  logic [QW-1:0]   s_r, t_val;
  logic [2*QW-1:0] ssq_r, tsq;
  logic [SCW-1:0]  scnt_r;
  logic            sbusy_r, srnd_r, sdone_r;

  // divider
  logic [DD-1:0]                  div_a, quot;
  logic [ucb_csr_pkg::DIVS_W-1:0] div_b;
  logic                           div_done;

  // arm evaluation
  logic [SW-1:0]                       rd_sum;
  logic [PW-1:0]                       rd_play;
  logic                                pess, coin;
  logic [ucb_csr_pkg::POS_W-1:0]       pos;
  logic signed [ucb_csr_pkg::MEAN_W-1:0] mean, isum;
  logic signed [ucb_csr_pkg::IDX_W-1:0]  idx;
  logic signed [ucb_csr_pkg::IDX_W-1:0]  best_idx_r;
  logic [ucb_csr_pkg::ARM_W-1:0]       best_arm_r;
  logic [ucb_csr_pkg::CH_W-1:0]        best_ch_r;
  logic [ucb_csr_pkg::SF_W-1:0]        best_sf_r;
  logic [ucb_csr_pkg::ADDR_W-1:0]      best_addr_r;
  logic [SW-1:0]                       best_sum_r;
  logic [PW-1:0]                       best_play_r;
  logic                                take;
  logic                                got;
  logic [SW:0]                         sum_add;

  always_comb begin
    e_top = '0;
    for (int i = 0; i < RB; i++) begin
      if (round_r[i]) e_top = ucb_csr_pkg::E_W'(i);
    end
  end

  assign xsq     = x_r * x_r;
  assign xsh     = xsq[61:30];
  assign ln_prod = 52'({e_r, frac_r}) * 52'(ucb_csr_pkg::LN2_Q32) + 52'(64'h8000_0000);

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      e_r    <= e_top;
      x_r    <= ucb_csr_pkg::X_W'({15'b0, round_r} << (5'd30 - 5'(e_top)));
      frac_r <= '0;
      lcnt_r <= '0;
    end else if (lbusy_r) begin
      if (lcnt_r == LCW'(ucb_csr_pkg::FRAC_W)) begin
        ln_r <= ln_prod[51:32];
      end else begin
        // squaring step: one fraction bit
        if (xsh[31]) begin
          x_r    <= xsh[31:1];
          frac_r <= {frac_r[ucb_csr_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          x_r    <= xsh[30:0];
          frac_r <= {frac_r[ucb_csr_pkg::FRAC_W-2:0], 1'b0};
        end
      end
      lcnt_r <= lcnt_r + 1'b1;
    end
    if (!rst_n) begin
      lbusy_r <= 1'b0;
      ldone_r <= 1'b0;
    end else begin
      ldone_r <= lbusy_r && (lcnt_r == LCW'(ucb_csr_pkg::FRAC_W));
      if (cmd.round_start)
        lbusy_r <= 1'b1;
      else if (lcnt_r == LCW'(ucb_csr_pkg::FRAC_W))
        lbusy_r <= 1'b0;
    end
  end

  assign rd_sum  = sum_mem[cmd.addr];
  assign rd_play = play_mem[cmd.addr];

  always_comb begin
    if (cmd.mdiv_start) begin
      div_a = DD'({rd_sum, 16'b0}) + DD'(rd_play) * DD'(5);
      div_b = ucb_csr_pkg::DIVS_W'(rd_play) * ucb_csr_pkg::DIVS_W'(10);
    end else begin
      div_a = {ln_r, 17'b0};
      div_b = ucb_csr_pkg::DIVS_W'(rd_play) + 1'b1;
    end
  end

  ucb_csr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.vdiv_start | cmd.mdiv_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quot)
  );

  assign t_val = s_r | (QW'(1) << scnt_r);
  assign tsq   = t_val * t_val;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      v_r    <= quot;
      s_r    <= '0;
      ssq_r  <= '0;
      scnt_r <= SCW'(QW - 1);
    end else if (sbusy_r) begin
      if (tsq <= {1'b0, v_r}) begin
        s_r   <= t_val;
        ssq_r <= tsq;
      end
      scnt_r <= scnt_r - 1'b1;
    end else if (srnd_r) begin
      if ((v_r - DD'(ssq_r)) > DD'(s_r)) s_r <= s_r + 1'b1;
    end
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      srnd_r  <= 1'b0;
      sdone_r <= 1'b0;
    end else begin
      sdone_r <= srnd_r;
      srnd_r  <= sbusy_r && (scnt_r == '0);
      if (cmd.sqrt_start)
        sbusy_r <= 1'b1;
      else if (scnt_r == '0)
        sbusy_r <= 1'b0;
    end
  end

  assign stat.log_done  = ldone_r;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sdone_r;

  assign pess = (cmd.dev < ucb_csr_pkg::DEV_W'(ucb_csr_pkg::MASK_W)) &&
                mask_r[cmd.dev];
  assign pos  = ucb_csr_pkg::POS_W'(cmd.dev) * ucb_csr_pkg::POS_W'(ucb_csr_pkg::ARMS - 1)
              + ucb_csr_pkg::POS_W'(cmd.arm) - 1'b1;
  assign coin = (pos < ucb_csr_pkg::POS_W'(ucb_csr_pkg::COIN_W)) ? coins_r[pos] : 1'b0;

  always_comb begin
    if (rd_play == '0)
      mean = pess ? -ucb_csr_pkg::MEAN_ONE : ucb_csr_pkg::MEAN_ONE;
    else
      mean = ucb_csr_pkg::MEAN_W'(quot);
    isum = mean + ucb_csr_pkg::MEAN_W'(s_r);
    if (isum > ucb_csr_pkg::IDX_HI)
      idx = ucb_csr_pkg::IDX_HI[ucb_csr_pkg::IDX_W-1:0];
    else if (isum < ucb_csr_pkg::IDX_LO)
      idx = ucb_csr_pkg::IDX_LO[ucb_csr_pkg::IDX_W-1:0];
    else
      idx = isum[ucb_csr_pkg::IDX_W-1:0];
  end

  assign take    = (cmd.arm == '0) || (idx > best_idx_r) ||
                   ((idx == best_idx_r) && !coin);
  assign got     = !taken_r[best_arm_r];
  assign sum_add = {1'b0, best_sum_r} + (got ? (SW+1)'(9) : (SW+1)'(1));

  always_ff @(posedge clk) begin
    if (cmd.round_start) coins_r <= tie_coins;
    if (cmd.compare && take) begin
      best_idx_r  <= idx;
      best_arm_r  <= cmd.arm;
      best_ch_r   <= cmd.ch;
      best_sf_r   <= cmd.sf;
      best_addr_r <= cmd.addr;
      best_sum_r  <= rd_sum;
      best_play_r <= rd_play;
    end
    if (cmd.update) begin
      device_index     <= 3'(cmd.dev);
      chosen_channel   <= best_ch_r[0];
      chosen_spreading <= 2'(best_sf_r);
      delivered        <= got;
      delivered_total  <= (got && dcnt_r != ucb_csr_pkg::CNT_MAX) ? dcnt_r + 1'b1 : dcnt_r;
      last_of_round    <= (cmd.dev == ucb_csr_pkg::DEV_W'(ucb_csr_pkg::DEVICES - 1));
    end
    if (!rst_n) begin
      round_r <= RB'(1);
      mask_r  <= '0;
      taken_r <= '0;
      dcnt_r  <= '0;
      for (int i = 0; i < ucb_csr_pkg::ENTRIES; i++) begin
        sum_mem[i]  <= '0;
        play_mem[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) mask_r <= cfg_wr_data;
      if (cmd.round_start) taken_r <= '0;
      if (cmd.round_end && round_r != '1) round_r <= round_r + 1'b1;
      if (cmd.update) begin
        taken_r[best_arm_r] <= 1'b1;
        if (got && dcnt_r != ucb_csr_pkg::CNT_MAX) dcnt_r <= dcnt_r + 1'b1;
        // freeze the arm once its play count is full
        if (best_play_r != ucb_csr_pkg::PLAY_MAX) begin
          sum_mem[best_addr_r]  <= sum_add[SW] ? ucb_csr_pkg::SUM_MAX : sum_add[SW-1:0];
          play_mem[best_addr_r] <= best_play_r + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ucb_channel_selection_round_unit.sv =====
// Channel    Direction  Ports
// input      in         in_valid, in_stall, in_tie_coins
// result     out        out_valid, out_stall, out_device_index .. out_last_of_round
// config     in         cfg_wr_en, cfg_wr_data
//
// One transaction in is one round and gives one result per device.
// Each arm runs two passes of the shared divider (exploration term and mean),
// a square root and a compare; each device adds an update step and a result
// step, each round starts with the log, and output stalls lengthen a round.
// Reset is synchronous; it clears the round counter to 1 and the arm tables.
// Input is stalled for the whole round; a stalled result simply holds.
`default_nettype none
module ucb_channel_selection_round_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ucb_csr_pkg::COIN_W-1:0]     in_tie_coins,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [2:0]                              out_device_index,
  output logic                                    out_chosen_channel,
  output logic [1:0]                              out_chosen_spreading,
  output logic                                    out_delivered,
  output logic [ucb_csr_pkg::CNT_W-1:0]           out_delivered_total,
  output logic                                    out_last_of_round,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ucb_csr_pkg::MASK_W-1:0]     cfg_wr_data
);
  ucb_csr_pkg::cmd_t  cmd;
  ucb_csr_pkg::stat_t stat;

  ucb_csr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ucb_csr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .tie_coins        (in_tie_coins),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .device_index     (out_device_index),
    .chosen_channel   (out_chosen_channel),
    .chosen_spreading (out_chosen_spreading),
    .delivered        (out_delivered),
    .delivered_total  (out_delivered_total),
    .last_of_round    (out_last_of_round)
  );
endmodule
`default_nettype wire

// ===== verif/ucb_channel_selection_round_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module ucb_channel_selection_round_unit_tb;

  localparam int HOLD_CYCLES = 6000;

  typedef struct packed {
    logic [2:0]                    dev;
    logic                          ch;
    logic [1:0]                    sf;
    logic                          dlv;
    logic [ucb_csr_pkg::CNT_W-1:0] total;
    logic                          last;
  } slot_pick_t;

  typedef struct {
    logic [ucb_csr_pkg::COIN_W-1:0] coins;
    bit                             typed;
    slot_pick_t                     first_pick;
  } coin_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ucb_csr_pkg::COIN_W-1:0] in_tie_coins = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [2:0]                     out_device_index;
  logic                           out_chosen_channel;
  logic [1:0]                     out_chosen_spreading;
  logic                           out_delivered;
  logic [ucb_csr_pkg::CNT_W-1:0]  out_delivered_total;
  logic                           out_last_of_round;
  logic                           cfg_wr_en = 1'b0;
  logic [ucb_csr_pkg::MASK_W-1:0] cfg_wr_data = '0;

  // predictor state
  int unsigned tenths_sum[ucb_csr_pkg::DEVICES][ucb_csr_pkg::ARMS];
  int unsigned arm_plays[ucb_csr_pkg::DEVICES][ucb_csr_pkg::ARMS];
  int unsigned deliveries;
  int unsigned round_no;
  logic [ucb_csr_pkg::MASK_W-1:0] start_mask;

  slot_pick_t picks_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_tok = 0;
  int hold_ack = 0;
  int hold_left = 0;

  coin_row_t coin_rows[$];

  ucb_channel_selection_round_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_tie_coins(in_tie_coins),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_device_index(out_device_index), .out_chosen_channel(out_chosen_channel),
    .out_chosen_spreading(out_chosen_spreading), .out_delivered(out_delivered),
    .out_delivered_total(out_delivered_total), .out_last_of_round(out_last_of_round),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  initial begin
    #60_000_000;
    $display("ucb_channel_selection_round_unit_tb: FAIL");
    $finish;
  end

  function automatic longint unsigned ln_fixed(longint unsigned r);
    longint unsigned x;
    longint unsigned frac;
    longint unsigned l2;
    int e;
    frac = 0;
    e = 0;
    if (r == 0) return 0;
    while (e < 63 && (r >> (e + 1)) != 0) e++;
    if (e <= 30) x = r << (30 - e);
    else x = r >> (e - 30);
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    l2 = (longint'(e) << 16) | frac;
    return (l2 * 64'd2977044472 + (64'd1 << 31)) >> 32;
  endfunction

  function automatic longint unsigned sqrt_near(longint unsigned v);
    longint unsigned s;
    longint unsigned t;
    s = 0;
    for (int b = 31; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if (t * t <= v) s = t;
    end
    if (v - s * s > s) s++;
    return s;
  endfunction

  function automatic longint arm_score(int d, int a, longint unsigned lnr);
    longint unsigned p;
    longint unsigned v;
    longint mean;
    longint score;
    p = arm_plays[d][a];
    v = ((2 * lnr) << 16) / (p + 1);
    if (p == 0) mean = start_mask[d] ? -65536 : 65536;
    else mean = longint'((longint'(tenths_sum[d][a]) * 65536 + 5 * p) / (10 * p));
    score = mean + longint'(sqrt_near(v));
    if (score > 524287) score = 524287;
    if (score < -524288) score = -524288;
    return score;
  endfunction

  // one round: queue a pick per device and advance the tables
  task automatic play_round(logic [ucb_csr_pkg::COIN_W-1:0] coins);
    longint unsigned lnr;
    longint best_score;
    longint sc;
    int best;
    bit taken[ucb_csr_pkg::ARMS];
    bit got;
    int unsigned s;
    slot_pick_t pk;
    lnr = ln_fixed(round_no);
    taken = '{default: 0};
    for (int d = 0; d < ucb_csr_pkg::DEVICES; d++) begin
      best = 0;
      best_score = arm_score(d, 0, lnr);
      for (int a = 1; a < ucb_csr_pkg::ARMS; a++) begin
        sc = arm_score(d, a, lnr);
        if (sc > best_score ||
            (sc == best_score && !coins[d * (ucb_csr_pkg::ARMS - 1) + a - 1])) begin
          best_score = sc;
          best = a;
        end
      end
      got = !taken[best];
      taken[best] = 1;
      if (got && deliveries < 20'hFFFFF) deliveries++;
      if (arm_plays[d][best] < 16'hFFFF) begin
        s = tenths_sum[d][best] + (got ? 9 : 1);
        tenths_sum[d][best] = s > 20'hFFFFF ? 20'hFFFFF : s;
        arm_plays[d][best]++;
      end
      pk.dev = 3'(d);
      pk.ch = 1'(best / ucb_csr_pkg::SPREAD_FACTORS);
      pk.sf = 2'(best % ucb_csr_pkg::SPREAD_FACTORS);
      pk.dlv = got;
      pk.total = ucb_csr_pkg::CNT_W'(deliveries);
      pk.last = (d == ucb_csr_pkg::DEVICES - 1);
      picks_due.push_back(pk);
    end
    if (round_no < (1 << ucb_csr_pkg::ROUND_BITS) - 1) round_no++;
  endtask

  task automatic report_mismatch(string what, longint got_v, longint want_v);
    $display("mismatch %s: got %0d expected %0d", what, got_v, want_v);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    slot_pick_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (picks_due.size() == 0) begin
        report_mismatch("unexpected transaction, device", out_device_index, -1);
      end else begin
        want = picks_due.pop_front();
        if (out_device_index !== want.dev)
          report_mismatch("device_index", out_device_index, want.dev);
        if (out_chosen_channel !== want.ch)
          report_mismatch("chosen_channel", out_chosen_channel, want.ch);
        if (out_chosen_spreading !== want.sf)
          report_mismatch("chosen_spreading", out_chosen_spreading, want.sf);
        if (out_delivered !== want.dlv)
          report_mismatch("delivered", out_delivered, want.dlv);
        if (out_delivered_total !== want.total)
          report_mismatch("delivered_total", out_delivered_total, want.total);
        if (out_last_of_round !== want.last)
          report_mismatch("last_of_round", out_last_of_round, want.last);
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (hold_tok != hold_ack) begin
      hold_ack <= hold_tok;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_round(logic [ucb_csr_pkg::COIN_W-1:0] coins, bit typed,
                            slot_pick_t first_pick);
    in_valid <= 1'b1;
    in_tie_coins <= coins;
    do @(posedge clk); while (in_stall);
    play_round(coins);
    if (typed) picks_due[picks_due.size() - ucb_csr_pkg::DEVICES] = first_pick;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_and_set_mask(logic [ucb_csr_pkg::MASK_W-1:0] m);
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_mask = m;
  endtask

  task automatic random_rounds(int n);
    for (int i = 0; i < n; i++)
      send_round(ucb_csr_pkg::COIN_W'($urandom()), 0, '0);
  endtask

  initial begin
    slot_pick_t none;
    none = '0;
    round_no = 1;
    deliveries = 0;
    start_mask = '0;
    for (int d = 0; d < ucb_csr_pkg::DEVICES; d++)
      for (int a = 0; a < ucb_csr_pkg::ARMS; a++) begin
        tenths_sum[d][a] = 0;
        arm_plays[d][a] = 0;
      end

    // first round after reset: every arm ties, coin 0 carries to the last arm
    coin_rows.push_back(coin_row_t'{25'h0000000, 1,
                                    '{3'd0, 1'b1, 2'd2, 1'b1, 20'd1, 1'b0}});
    coin_rows.push_back(coin_row_t'{25'h1FFFFFF, 0, none});
    coin_rows.push_back(coin_row_t'{25'h1555555, 0, none});
    coin_rows.push_back(coin_row_t'{25'h0AAAAAA, 0, none});
    coin_rows.push_back(coin_row_t'{25'h000001F, 0, none});
    coin_rows.push_back(coin_row_t'{25'h00003E0, 0, none});
    coin_rows.push_back(coin_row_t'{25'h0007C00, 0, none});
    coin_rows.push_back(coin_row_t'{25'h00F8000, 0, none});
    coin_rows.push_back(coin_row_t'{25'h1F00000, 0, none});
    coin_rows.push_back(coin_row_t'{25'h1000001, 0, none});
    coin_rows.push_back(coin_row_t'{25'h0000000, 0, none});
    coin_rows.push_back(coin_row_t'{25'h1FFFFFF, 0, none});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, mask zero, no idling
    drain_and_set_mask(5'b00000);
    foreach (coin_rows[i]) send_round(coin_rows[i].coins, coin_rows[i].typed,
                                      coin_rows[i].first_pick);

    drain_and_set_mask(5'b11111);
    send_idle_pct = 50;
    random_rounds(50);

    drain_and_set_mask(5'b00000);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    random_rounds(50);

    drain_and_set_mask(5'b10101);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    random_rounds(50);

    // hold the result side while the sender keeps offering
    drain_and_set_mask(5'b01010);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_tok <= hold_tok + 1;
    random_rounds(58);

    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("ucb_channel_selection_round_unit_tb: PASS");
    else $display("ucb_channel_selection_round_unit_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== ucb_channel_selection_round_unit.f =====
rtl/core/ucb_csr_pkg.sv
rtl/core/ucb_csr_div.sv
rtl/core/ucb_csr_ctrl.sv
rtl/core/ucb_csr_dp.sv
rtl/core/ucb_channel_selection_round_unit.sv
verif/ucb_channel_selection_round_unit_tb.sv
